FILE: rtl/core/tgv_pkg.sv
// shared types and register indexes for the triangle grid vertex generator
package tgv_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_CORNER_TOP   = 3'd0;
   localparam logic [2:0] CSR_CORNER_LEFT  = 3'd1;
   localparam logic [2:0] CSR_CORNER_RIGHT = 3'd2;
   localparam logic [2:0] CSR_TEX_TOP      = 3'd3;
   localparam logic [2:0] CSR_TEX_RIGHT    = 3'd4;
   localparam logic [2:0] CSR_ROW_COUNT    = 3'd5;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUB1,
      ST_MUL1,
      ST_SUB2,
      ST_MUL2,
      ST_ABS,
      ST_DIV,
      ST_SIGN,
      ST_STORE,
      ST_OUTPUT
   } tgv_state_type;

   // quantity being worked on by the shared datapath
   typedef enum logic [2:0] {
      QTY_X,
      QTY_Y,
      QTY_Z,
      QTY_U,
      QTY_V
   } tgv_qty_type;

endpackage

FILE: rtl/core/triangle_grid_vertex_generator_core.sv
// triangle grid vertex generator: one vertex of a tessellated triangle per request
//
// Each request on the req_ channel yields one vertex of a uniform grid that cuts the
// triangle held in the corner registers into row_count rows, walked from the apex
// downward and left to right within a row. A request with restart set (req_tdata[0])
// starts a new tile at the apex; the last vertex of a tile carries rsp_tlast, and the
// request after it starts a new tile. The five results (x, y, z, u, v) are worked
// out one after another by a single multiply-accumulate and a bit-serial restoring
// divider by the row count, the divider's one bit per cycle being the bulk of the
// work for a request. A finished vertex waits in an output register, so the next
// request is taken while the previous response is still pending. Configuration
// writes are meant for idle periods only.
module triangle_grid_vertex_generator_core
   import tgv_pkg::*;
#(
   parameter int MAX_ROWS   = 255,
   parameter int COORD_BITS = 21
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [0] restart
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // [20:0] pos_x, [41:21] pos_y, [62:42] pos_z,
                                     // [78:63] tex_u, [94:79] tex_v,
                                     // [110:95] vertex_number
   output logic         rsp_tlast,   // last_of_tile
   // configuration write port
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [62:0]  csr_wdata
);

   localparam int DIFF_W = (COORD_BITS + 1 > 17) ? COORD_BITS + 1 : 17;
   localparam int PROD_W = DIFF_W + 9;
   localparam int ACC_W  = DIFF_W + 10;
   localparam int CNT_W  = $clog2(ACC_W);

   // sign-extended coordinate of one packed axis field
   function automatic logic signed [DIFF_W-1:0] coord_field(input logic [62:0] word,
                                                            input int unsigned field);
      logic [COORD_BITS-1:0] raw;
      raw = word[field*COORD_BITS +: COORD_BITS];
      return DIFF_W'(signed'(raw));
   endfunction

   // configuration registers
   logic [62:0] corner_top_ff, corner_left_ff, corner_right_ff;
   logic [31:0] tex_top_ff, tex_right_ff;
   logic [7:0]  row_count_ff;

   // walk state
   logic [7:0]  row_now_ff, row_now_in;
   logic [7:0]  column_now_ff, column_now_in;
   logic [15:0] vertex_counter_ff, vertex_counter_in;

   // current item
   logic [7:0]  cur_i_ff, cur_i_in;
   logic [7:0]  cur_j_ff, cur_j_in;
   logic [15:0] cur_vnum_ff, cur_vnum_in;
   logic        cur_last_ff, cur_last_in;

   // sequencer and shared datapath
   tgv_state_type             state_ff, state_in;
   tgv_qty_type               sel_ff, sel_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic [7:0]                factor_ff, factor_in;
   logic signed [ACC_W-1:0]   work_ff, work_in;
   logic                      neg_ff, neg_in;
   logic [7:0]                rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // finished results and output register
   logic [20:0] res_x_ff, res_x_in, res_y_ff, res_y_in, res_z_ff, res_z_in;
   logic [15:0] res_u_ff, res_u_in, res_v_ff, res_v_in;
   logic [110:0] out_data_ff, out_data_in;
   logic         out_last_ff, out_last_in;
   logic         out_valid_ff, out_valid_in;

   // effective row count
   logic [7:0] n_eff;
   always_comb begin
      if (row_count_ff == 8'd0) begin
         n_eff = 8'd1;
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         n_eff = 8'(MAX_ROWS);
      end else begin
         n_eff = row_count_ff;
      end
   end

   // handshake
   logic req_fire, out_free;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};
   assign rsp_tlast  = out_last_ff;

   // start point and advance of the walk
   logic        wrap;
   logic [7:0]  start_i, start_j;
   logic [15:0] start_vnum;
   logic        start_last;
   logic [8:0]  col_next, row_next;
   always_comb begin
      wrap       = req_tdata[0] || (row_now_ff > n_eff) || (column_now_ff > row_now_ff);
      start_i    = wrap ? 8'd0 : row_now_ff;
      start_j    = wrap ? 8'd0 : column_now_ff;
      start_vnum = wrap ? 16'd0 : vertex_counter_ff;
      start_last = (start_i == n_eff) && (start_j == n_eff);
      col_next   = {1'b0, start_j} + 9'd1;
      row_next   = {1'b0, start_i};
      if (col_next > {1'b0, start_i}) begin
         col_next = 9'd0;
         row_next = {1'b0, start_i} + 9'd1;
      end
   end

   // operand selection for the current quantity
   logic signed [DIFF_W-1:0] top_c, left_c, right_c;
   logic signed [DIFF_W-1:0] u0_e, v0_e, u2_e, v2_e;
   logic signed [DIFF_W-1:0] hi1, lo1, hi2, lo2;
   logic [7:0]               fac1, fac2;
   logic signed [ACC_W-1:0]  base;
   always_comb begin
      u0_e = DIFF_W'({1'b0, tex_top_ff[31:16]});
      v0_e = DIFF_W'({1'b0, tex_top_ff[15:0]});
      u2_e = DIFF_W'({1'b0, tex_right_ff[31:16]});
      v2_e = DIFF_W'({1'b0, tex_right_ff[15:0]});
      case (sel_ff)
         QTY_X: begin
            top_c   = coord_field(corner_top_ff, 2);
            left_c  = coord_field(corner_left_ff, 2);
            right_c = coord_field(corner_right_ff, 2);
         end
         QTY_Y: begin
            top_c   = coord_field(corner_top_ff, 1);
            left_c  = coord_field(corner_left_ff, 1);
            right_c = coord_field(corner_right_ff, 1);
         end
         default: begin
            top_c   = coord_field(corner_top_ff, 0);
            left_c  = coord_field(corner_left_ff, 0);
            right_c = coord_field(corner_right_ff, 0);
         end
      endcase
      case (sel_ff)
         QTY_U: begin
            hi1  = u2_e;
            lo1  = u0_e;
            hi2  = '0;
            lo2  = '0;
            fac1 = cur_j_ff;
            fac2 = 8'd0;
            base = ACC_W'(u0_e);
         end
         QTY_V: begin
            hi1  = v2_e;
            lo1  = v0_e;
            hi2  = '0;
            lo2  = '0;
            fac1 = (cur_i_ff == 8'd0) ? 8'd0 : n_eff - cur_i_ff;
            fac2 = 8'd0;
            base = ACC_W'(v0_e);
         end
         default: begin
            hi1  = left_c;
            lo1  = top_c;
            hi2  = right_c;
            lo2  = left_c;
            fac1 = cur_i_ff;
            fac2 = cur_j_ff;
            base = ACC_W'(top_c);
         end
      endcase
   end

   // shared multiplier and divider step
   logic signed [PROD_W-1:0] prod;
   logic [8:0]               rem_sh;
   logic                     rem_ge;
   logic signed [ACC_W-1:0]  sum;
   assign prod   = PROD_W'(diff_ff) * PROD_W'($signed({1'b0, factor_ff}));
   assign rem_sh = {rem_ff, work_ff[ACC_W-1]};
   assign rem_ge = rem_sh >= {1'b0, n_eff};
   assign sum    = work_ff + base;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_SUB1;
         ST_SUB1:   state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_SUB2;
         ST_SUB2:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_ABS;
         ST_ABS:    state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == '0) state_in = ST_SIGN;
         ST_SIGN:   state_in = ST_STORE;
         ST_STORE:  state_in = (sel_ff == QTY_V) ? ST_OUTPUT : ST_SUB1;
         ST_OUTPUT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and output register updates
   always_comb begin
      row_now_in        = row_now_ff;
      column_now_in     = column_now_ff;
      vertex_counter_in = vertex_counter_ff;
      cur_i_in          = cur_i_ff;
      cur_j_in          = cur_j_ff;
      cur_vnum_in       = cur_vnum_ff;
      cur_last_in       = cur_last_ff;
      sel_in            = sel_ff;
      diff_in           = diff_ff;
      factor_in         = factor_ff;
      work_in           = work_ff;
      neg_in            = neg_ff;
      rem_in            = rem_ff;
      cnt_in            = cnt_ff;
      res_x_in          = res_x_ff;
      res_y_in          = res_y_ff;
      res_z_in          = res_z_ff;
      res_u_in          = res_u_ff;
      res_v_in          = res_v_ff;
      out_data_in       = out_data_ff;
      out_last_in       = out_last_ff;
      out_valid_in      = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_i_in    = start_i;
               cur_j_in    = start_j;
               cur_vnum_in = start_vnum;
               cur_last_in = start_last;
               sel_in      = QTY_X;
               if (row_next > {1'b0, n_eff}) begin
                  row_now_in        = 8'd0;
                  column_now_in     = 8'd0;
                  vertex_counter_in = 16'd0;
               end else begin
                  row_now_in        = row_next[7:0];
                  column_now_in     = col_next[7:0];
                  vertex_counter_in = start_vnum + 16'd1;
               end
            end
         end
         ST_SUB1: begin
            diff_in   = hi1 - lo1;
            factor_in = fac1;
         end
         ST_MUL1: begin
            work_in = ACC_W'(prod);
         end
         ST_SUB2: begin
            diff_in   = hi2 - lo2;
            factor_in = fac2;
         end
         ST_MUL2: begin
            work_in = work_ff + ACC_W'(prod);
         end
         ST_ABS: begin
            neg_in  = work_ff[ACC_W-1];
            work_in = work_ff[ACC_W-1] ? -work_ff : work_ff;
            rem_in  = 8'd0;
            cnt_in  = CNT_W'(ACC_W - 1);
         end
         ST_DIV: begin
            rem_in  = rem_ge ? 8'(rem_sh - {1'b0, n_eff}) : rem_sh[7:0];
            work_in = {work_ff[ACC_W-2:0], rem_ge};
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         ST_SIGN: begin
            // floor toward minus infinity for negative numerators
            if (neg_ff) begin
               work_in = -work_ff - ACC_W'(rem_ff != 8'd0);
            end
         end
         ST_STORE: begin
            case (sel_ff)
               QTY_X: begin
                  res_x_in = sum[20:0];
                  sel_in   = QTY_Y;
               end
               QTY_Y: begin
                  res_y_in = sum[20:0];
                  sel_in   = QTY_Z;
               end
               QTY_Z: begin
                  res_z_in = sum[20:0];
                  sel_in   = QTY_U;
               end
               QTY_U: begin
                  res_u_in = sum[15:0];
                  sel_in   = QTY_V;
               end
               default: begin
                  res_v_in = sum[15:0];
               end
            endcase
         end
         ST_OUTPUT: begin
            if (out_free) begin
               out_data_in  = {cur_vnum_ff, res_v_ff, res_u_ff, res_z_ff, res_y_ff, res_x_ff};
               out_last_in  = cur_last_ff;
               out_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_top_ff   <= '0;
         corner_left_ff  <= '0;
         corner_right_ff <= '0;
         tex_top_ff      <= '0;
         tex_right_ff    <= '0;
         row_count_ff    <= 8'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CORNER_TOP:   corner_top_ff   <= csr_wdata;
            CSR_CORNER_LEFT:  corner_left_ff  <= csr_wdata;
            CSR_CORNER_RIGHT: corner_right_ff <= csr_wdata;
            CSR_TEX_TOP:      tex_top_ff      <= csr_wdata[31:0];
            CSR_TEX_RIGHT:    tex_right_ff    <= csr_wdata[31:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         row_now_ff        <= 8'd0;
         column_now_ff     <= 8'd0;
         vertex_counter_ff <= 16'd0;
         out_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         row_now_ff        <= row_now_in;
         column_now_ff     <= column_now_in;
         vertex_counter_ff <= vertex_counter_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_i_ff    <= cur_i_in;
      cur_j_ff    <= cur_j_in;
      cur_vnum_ff <= cur_vnum_in;
      cur_last_ff <= cur_last_in;
      sel_ff      <= sel_in;
      diff_ff     <= diff_in;
      factor_ff   <= factor_in;
      work_ff     <= work_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_z_ff    <= res_z_in;
      res_u_ff    <= res_u_in;
      res_v_ff    <= res_v_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   // the walk never points past the diagonal of its row
   a_col_within_row: assert property (@(posedge clock) disable iff (reset)
      column_now_ff <= row_now_ff)
      else $error("column index beyond row index");

   // the last vertex of a tile sends the walk back to the apex
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      req_fire && start_last |=> row_now_ff == 8'd0 && column_now_ff == 8'd0
                                 && vertex_counter_ff == 16'd0)
      else $error("walk not reset after last vertex");

   // the partial remainder stays below the divisor during the divide
   a_rem_below_n: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < n_eff)
      else $error("divider remainder out of range");

   // a finished vertex always lands in the output register
   a_output_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUTPUT && state_in == ST_IDLE |=> out_valid_ff)
      else $error("finished vertex not presented");

endmodule

FILE: dv/tgv_checker.sv
// vertex predictor and response checker for the triangle grid vertex generator
`timescale 1ns / 100ps

module tgv_checker
   import tgv_pkg::*;
#(
   parameter int MAX_ROWS = 255
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [62:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);

   localparam int COORD_W = 21;

   typedef struct {
      logic [20:0] pos_x;
      logic [20:0] pos_y;
      logic [20:0] pos_z;
      logic [15:0] tex_u;
      logic [15:0] tex_v;
      logic [15:0] vertex_number;
      logic        last_of_tile;
   } vertex_type;

   // shadow copy of the configuration registers
   logic [62:0] corner_top_cfg, corner_left_cfg, corner_right_cfg;
   logic [31:0] tex_top_cfg, tex_right_cfg;
   logic [7:0]  rows_cfg;

   // grid walk position of the next vertex
   int unsigned row_now, col_now;
   logic [15:0] vertex_index;

   vertex_type expected_vertices[$];
   vertex_type want, got;

   // division rounding toward minus infinity
   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   // one position axis; field 2 is x, field 0 is z
   function automatic logic [20:0] axis_position(int field, int unsigned i, int unsigned j,
                                                 int unsigned n);
      longint a, b, c, num;
      logic [63:0] p;
      a = longint'($signed(corner_top_cfg[field*COORD_W +: COORD_W]));
      b = longint'($signed(corner_left_cfg[field*COORD_W +: COORD_W]));
      c = longint'($signed(corner_right_cfg[field*COORD_W +: COORD_W]));
      num = longint'(i) * (b - a) + longint'(j) * (c - b);
      p = a + floor_quot(num, longint'(n));
      return p[20:0];
   endfunction

   // predict the vertex for one request and advance the walk
   function automatic vertex_type next_vertex(logic restart);
      vertex_type r;
      int unsigned n, i, j;
      longint u0, v0, u2, v2;
      logic [63:0] u, v;
      n = rows_cfg;
      if (n == 0) n = 1;
      if (n > MAX_ROWS) n = MAX_ROWS;
      // restart, or a walk that no longer fits the grid
      if (restart || row_now > n || col_now > row_now) begin
         row_now = 0;
         col_now = 0;
         vertex_index = '0;
      end
      i = row_now;
      j = col_now;
      r.pos_x = axis_position(2, i, j, n);
      r.pos_y = axis_position(1, i, j, n);
      r.pos_z = axis_position(0, i, j, n);
      u0 = longint'(tex_top_cfg[31:16]);
      v0 = longint'(tex_top_cfg[15:0]);
      u2 = longint'(tex_right_cfg[31:16]);
      v2 = longint'(tex_right_cfg[15:0]);
      if (i == 0) begin
         u = u0;
         v = v0;
      end else begin
         u = u0 + floor_quot((u2 - u0) * longint'(j), longint'(n));
         v = v0 + floor_quot((v2 - v0) * longint'(n - i), longint'(n));
      end
      r.tex_u = u[15:0];
      r.tex_v = v[15:0];
      r.vertex_number = vertex_index;
      r.last_of_tile = (i == n && j == n);
      // step to the next column, or the next row
      col_now = j + 1;
      if (col_now > i) begin
         col_now = 0;
         row_now = i + 1;
      end
      if (row_now > n) begin
         row_now = 0;
         col_now = 0;
         vertex_index = '0;
      end else begin
         vertex_index = vertex_index + 16'd1;
      end
      return r;
   endfunction

   // track configuration, predict on requests, compare on responses
   always @(posedge clock) begin
      if (reset) begin
         corner_top_cfg = '0;
         corner_left_cfg = '0;
         corner_right_cfg = '0;
         tex_top_cfg = '0;
         tex_right_cfg = '0;
         rows_cfg = 8'd1;
         row_now = 0;
         col_now = 0;
         vertex_index = '0;
         expected_vertices.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CORNER_TOP:   corner_top_cfg = csr_wdata;
               CSR_CORNER_LEFT:  corner_left_cfg = csr_wdata;
               CSR_CORNER_RIGHT: corner_right_cfg = csr_wdata;
               CSR_TEX_TOP:      tex_top_cfg = csr_wdata[31:0];
               CSR_TEX_RIGHT:    tex_right_cfg = csr_wdata[31:0];
               CSR_ROW_COUNT:    rows_cfg = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_vertices.push_back(next_vertex(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            got.pos_x = rsp_tdata[20:0];
            got.pos_y = rsp_tdata[41:21];
            got.pos_z = rsp_tdata[62:42];
            got.tex_u = rsp_tdata[78:63];
            got.tex_v = rsp_tdata[94:79];
            got.vertex_number = rsp_tdata[110:95];
            got.last_of_tile = rsp_tlast;
            if (expected_vertices.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: vertex response with no request pending", $realtime);
               fail_count = fail_count + 1;
            end else begin
               want = expected_vertices.pop_front();
               if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                   got.pos_z !== want.pos_z || got.tex_u !== want.tex_u ||
                   got.tex_v !== want.tex_v || got.vertex_number !== want.vertex_number ||
                   got.last_of_tile !== want.last_of_tile) begin
                  if (fail_count < 10) begin
                     $display("%0t: vertex mismatch expected x=%h y=%h z=%h u=%h v=%h n=%0d last=%b",
                              $realtime, want.pos_x, want.pos_y, want.pos_z, want.tex_u,
                              want.tex_v, want.vertex_number, want.last_of_tile);
                     $display("%0t: vertex mismatch got      x=%h y=%h z=%h u=%h v=%h n=%0d last=%b",
                              $realtime, got.pos_x, got.pos_y, got.pos_z, got.tex_u,
                              got.tex_v, got.vertex_number, got.last_of_tile);
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending = expected_vertices.size();
   end

endmodule

FILE: dv/testbench.sv
// stimulus, clocking and verdict for the triangle grid vertex generator core
`timescale 1ns / 100ps

module testbench
   import tgv_pkg::*;
();

   localparam int ITEM_TARGET    = 1300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 250;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = CSR_CORNER_TOP;
   logic [62:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int requests_sent = 0;
   int quiet_cycles = 0;
   int phase_num;
   int burst_len;

   always #5 clock = ~clock;

   triangle_grid_vertex_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tgv_checker vertex_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // response side back-pressure
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("triangle_grid_vertex_generator_core verification failed");
            $finish;
         end
      end
   end

   // coordinate with a bias toward the extremes of the 21-bit range
   function automatic logic [20:0] pick_coord();
      int r;
      r = $urandom_range(9);
      case (r)
         0: return 21'h0FFFFF;
         1: return 21'h100000;
         2: return 21'h000000;
         default: return 21'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_tex();
      int r;
      r = $urandom_range(9);
      case (r)
         0: return 16'hFFFF;
         1: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // row count: mostly small grids, a few of the largest
   function automatic logic [7:0] pick_rows();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 8'd0;
      if (r < 70) return 8'($urandom_range(1, 6));
      if (r < 93) return 8'($urandom_range(7, 30));
      return 8'($urandom_range(200, 255));
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [62:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_config(input logic [62:0] top, input logic [62:0] left,
                              input logic [62:0] right, input logic [31:0] tex_t,
                              input logic [31:0] tex_r, input logic [7:0] rows);
      write_csr(CSR_CORNER_TOP, top);
      write_csr(CSR_CORNER_LEFT, left);
      write_csr(CSR_CORNER_RIGHT, right);
      write_csr(CSR_TEX_TOP, {31'd0, tex_t});
      write_csr(CSR_TEX_RIGHT, {31'd0, tex_r});
      write_csr(CSR_ROW_COUNT, {55'd0, rows});
   endtask

   task automatic load_random_config();
      load_config({pick_coord(), pick_coord(), pick_coord()},
                  {pick_coord(), pick_coord(), pick_coord()},
                  {pick_coord(), pick_coord(), pick_coord()},
                  {pick_tex(), pick_tex()}, {pick_tex(), pick_tex()}, pick_rows());
   endtask

   // one request, with optional idle cycles ahead of it; valid stays high on return
   task automatic send_request(input logic restart_bit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, restart_bit};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // stop requesting and wait for every response to come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
         default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero row count acts as one row: walk the whole tile, then wrap to the apex
      load_config({21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF},
                  {21'h100000, 21'h100000, 21'h100000},
                  {21'h0FFFFF, 21'h100000, 21'h000000},
                  32'hFFFF_0000, 32'h0000_FFFF, 8'd0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      drain();

      // largest row count with swapped extremes
      load_config({21'h100000, 21'h100000, 21'h100000},
                  {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF},
                  {21'h100000, 21'h0FFFFF, 21'h100000},
                  32'h0000_FFFF, 32'hFFFF_0000, 8'd255);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
      drain();

      // walk into row four of an eight row grid
      load_random_config();
      write_csr(CSR_ROW_COUNT, 63'd8);
      send_request(1'b1);
      repeat (10) send_request(1'b0);
      drain();

      // shrink the grid under the pending vertex: walk restarts at the apex
      write_csr(CSR_ROW_COUNT, 63'd2);
      send_request(1'b0);
      send_request(1'b0);
      drain();

      // random phases over rotating idling modes
      phase_num = 0;
      while (requests_sent < ITEM_TARGET) begin
         set_idling(phase_num);
         load_random_config();
         burst_len = $urandom_range(60, 150);
         repeat (burst_len) send_request($urandom_range(99) < 3);
         drain();
         phase_num++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("triangle_grid_vertex_generator_core verification clean");
      end else begin
         $display("triangle_grid_vertex_generator_core verification failed");
      end
      $finish;
   end

endmodule
